// ----- design/crc24_word_stream_macros.svh -----
// ---------------------------------------------------------------------------
// crc24_word_stream_macros.svh
// Assertion macros used by the CRC-24 word stream design.
// ---------------------------------------------------------------------------
`ifndef CRC24_WORD_STREAM_MACROS_SVH
`define CRC24_WORD_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CRC24_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CRC24_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/crc24_pkg.sv -----
// ---------------------------------------------------------------------------
// crc24_pkg
// Widths, constants and types of the CRC-24 word stream design.
// ---------------------------------------------------------------------------
package crc24_pkg;

  localparam int CrcWidth   = 24;
  localparam int DataWidth  = 32;
  localparam int ByteBits   = 8;
  localparam int CountWidth = 3;
  localparam int WordBytes  = DataWidth / ByteBits;

  // Default number of byte lanes per word
  localparam int BytesPerWordDefault = 4;

  // Generator polynomial after reset (CRC24A), x^24 term implicit
  localparam logic [CrcWidth-1:0] PolyReset = 24'h864CFB;

  typedef logic [CrcWidth-1:0] crc_t;
  typedef logic [ByteBits-1:0] byte_t;

endpackage

// ----- design/crc24_lane.sv -----
// ---------------------------------------------------------------------------
// crc24_lane
// One byte step of the MSB-first CRC-24: folds a byte into a remainder.
// ---------------------------------------------------------------------------
module crc24_lane import crc24_pkg::*; (
  input  crc_t  crc_i,
  input  byte_t byte_i,
  input  crc_t  poly_i,
  output crc_t  crc_o
);

  // Inject the byte at the top, then shift out eight bits
  always_comb begin
    crc_t c;
    c = crc_i ^ {byte_i, {(CrcWidth-ByteBits){1'b0}}};
    for (int b = 0; b < ByteBits; b++) begin
      if (c[CrcWidth-1]) begin
        c = {c[CrcWidth-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[CrcWidth-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// ----- design/crc24_merge.sv -----
// ---------------------------------------------------------------------------
// crc24_merge
// Picks the lane result that matches the valid byte count of a word.
// ---------------------------------------------------------------------------
module crc24_merge import crc24_pkg::*; #(
  parameter int NumLanes = BytesPerWordDefault
) (
  input  crc_t                  lane_crc_i [NumLanes+1],
  input  logic [CountWidth-1:0] count_i,
  output crc_t                  merged_o
);

  localparam int SelWidth = $clog2(NumLanes + 1);

  logic [SelWidth-1:0] sel;

  // Saturate the count to the number of lanes
  always_comb begin
    if (int'(count_i) > NumLanes) begin
      sel = SelWidth'(NumLanes);
    end else begin
      sel = SelWidth'(count_i);
    end
  end

  // Entry zero is the untouched remainder, entry k follows k bytes
  assign merged_o = lane_crc_i[sel];

endmodule

// ----- design/crc24_word_stream.sv -----
// ---------------------------------------------------------------------------
// crc24_word_stream
// MSB-first CRC-24, zero init, no final XOR, over words of up to four bytes.
// ---------------------------------------------------------------------------
//
//  port group   direction  handshake                payload
//  ----------   ---------  -----------------------  ------------------------
//  input        in         in_valid_i / in_stall_o  data_word_i, byte_count_i,
//                                                   last_word_i
//  output       out        out_valid_o/out_stall_i  crc_value_o
//  config       in         cfg_we_i                 cfg_data_i
//
//  One word per cycle unless in_stall_o is set; the byte lanes fold a full word
//  into the remainder combinationally, so the remainder loop sets the rate.
//  The CRC appears in the cycle after the last word's transfer.
//  Reset clears the remainder and loads the CRC24A polynomial.
//  The input stalls only while a finished CRC waits in the output register.
// ---------------------------------------------------------------------------
`include "crc24_word_stream_macros.svh"

module crc24_word_stream import crc24_pkg::*; #(
  parameter int BytesPerWord = BytesPerWordDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [DataWidth-1:0]  data_word_i,
  input  logic [CountWidth-1:0] byte_count_i,
  input  logic                  last_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CrcWidth-1:0]   crc_value_o,
  input  logic                  cfg_we_i,
  input  logic [CrcWidth-1:0]   cfg_data_i
);

  crc_t  poly_q;
  crc_t  rem_q, rem_d;
  logic  out_valid_q, out_valid_d;
  crc_t  crc_q;
  logic  in_xfer;
  crc_t  merged;
  crc_t  chain [BytesPerWord+1];
  byte_t lane_byte [BytesPerWord];

  // Accept a word unless a CRC is held up at the output
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // Hold the generator polynomial
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (cfg_we_i) begin
      poly_q <= cfg_data_i;
    end
  end

  // Build the lane chain, lanes above the word read zero bytes
  assign chain[0] = rem_q;
  for (genvar i = 0; i < BytesPerWord; i++) begin : g_lane
    if (i < WordBytes) begin : g_data
      assign lane_byte[i] = data_word_i[i*ByteBits +: ByteBits];
    end else begin : g_zero
      assign lane_byte[i] = '0;
    end
    crc24_lane u_lane (
      .crc_i  (chain[i]),
      .byte_i (lane_byte[i]),
      .poly_i (poly_q),
      .crc_o  (chain[i+1])
    );
  end

  // Merge lanes by byte count
  crc24_merge #(
    .NumLanes (BytesPerWord)
  ) u_merge (
    .lane_crc_i (chain),
    .count_i    (byte_count_i),
    .merged_o   (merged)
  );

  // Advance the remainder, clear it after the last word
  always_comb begin
    rem_d = rem_q;
    if (in_xfer) begin
      rem_d = last_word_i ? '0 : merged;
    end
  end

  // Load the output register on a last word, drop it once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer && last_word_i) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_word_i) begin
      crc_q <= merged;
    end
  end

  assign out_valid_o = out_valid_q;
  assign crc_value_o = crc_q;

  // Checks
  `CRC24_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, in_xfer && last_word_i, out_valid_q && rem_q == '0, "last word must load output and clear remainder")
  `CRC24_ASSERT_NEXT(a_crc_loaded, clk_i, rst_ni, in_xfer && last_word_i, crc_q == $past(merged), "output CRC must match merged lane result")
  `CRC24_ASSERT_NEXT(a_empty_word, clk_i, rst_ni, in_xfer && !last_word_i && byte_count_i == '0, rem_q == $past(rem_q), "empty word must leave remainder unchanged")
  `CRC24_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_q, "input stall without a pending CRC")

endmodule
